### design/rcft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_pkg: shared types and codes for the route cache
// Sequencer states, request mode codes and response status codes.
// ----------------------------------------------------------------------------
package rcft_pkg;

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int LIFE_BITS   = 8;

   localparam logic [LIFE_BITS-1:0] TTL_RESET = 8'd30;

   localparam logic [MODE_BITS-1:0] MODE_PUT  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_GET  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TICK = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_PRESENT  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EVICTED  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OTHER    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_REMAP,
      ST_RENUM,
      ST_RESP
   } seq_state_type;

endpackage
`default_nettype wire

### design/rcft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/route_cache_fifo_ttl_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route_cache_fifo_ttl_core: associative route cache, FIFO replacement, TTL
// Sequenced cache that walks its entry memory one entry per cycle.
// ----------------------------------------------------------------------------
// A put stores key and route as the newest entry (status 0), answers "already
// present" without touching the entry or its life (status 1), or evicts the
// oldest entry first when all ENTRIES slots are full (status 2). A get returns
// hit and route. A tick ages every entry and removes those whose life runs
// out, reporting how many went. Every transfer on the response side carries
// the occupancy after the item. The block takes one item at a time and holds
// req_stall high until the item's result is in the output register. Each get,
// put and tick sweeps the entry memory; a put of a new key sweeps it again to
// insert, and a tick in which an entry expires fills the rank remap table and
// then sweeps the entries again to renumber. The entry memory has one read
// port and is swept one entry per cycle through one shared key compare, life
// decrement and age-rank update. The life register (csr_wdata, reset 30) may
// be written whenever the block is idle; a value of zero gives a life of one
// tick.
// ----------------------------------------------------------------------------
module route_cache_fifo_ttl_core
   import rcft_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 48,
   parameter int ROUTE_BITS = 16,
   localparam int CNTW      = $clog2(ENTRIES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [MODE_BITS-1:0]   req_mode,
   input  wire logic [KEY_BITS-1:0]    req_key,
   input  wire logic [ROUTE_BITS-1:0]  req_route,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic      [ROUTE_BITS-1:0]  rsp_route_out,
   output logic      [STATUS_BITS-1:0] rsp_status,
   output logic      [CNTW-1:0]        rsp_expired_count,
   output logic      [CNTW-1:0]        rsp_occupancy,
   // life register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [LIFE_BITS-1:0]   csr_wdata
);

   localparam int IDXW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   // entry word: key | route | life | age rank
   localparam int LIFE_LO   = IDXW;
   localparam int ROUTE_LO  = LIFE_LO + LIFE_BITS;
   localparam int KEY_LO    = ROUTE_LO + ROUTE_BITS;
   localparam int WORD_BITS = KEY_LO + KEY_BITS;

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   seq_state_type state_ff, state_in;

   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic                     p1_vld_ff, p1_vld_in;
   logic [IDXW-1:0]          p1_idx_ff, p1_idx_in;
   logic                     p2_vld_ff, p2_vld_in;
   logic [IDXW-1:0]          p2_idx_ff, p2_idx_in;
   logic [WORD_BITS-1:0]     p2_word_ff, p2_word_in;

   logic [MODE_BITS-1:0]     mode_ff, mode_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [ROUTE_BITS-1:0]    route_ff, route_in;

   logic [ENTRIES-1:0]       valid_ff, valid_in;
   logic [CNTW-1:0]          count_ff, count_in;
   logic [LIFE_BITS-1:0]     ttl_ff, ttl_in;

   logic                     found_ff, found_in;
   logic [ROUTE_BITS-1:0]    rt_ff, rt_in;
   logic                     free_found_ff, free_found_in;
   logic [IDXW-1:0]          slot_ff, slot_in;
   logic [IDXW-1:0]          victim_ff, victim_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic [CNTW-1:0]          expired_ff, expired_in;
   logic [ENTRIES-1:0]       expmask_ff, expmask_in;
   logic [CNTW-1:0]          run_ff, run_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [ROUTE_BITS-1:0]    rsp_route_ff, rsp_route_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [CNTW-1:0]          rsp_expired_ff, rsp_expired_in;
   logic [CNTW-1:0]          rsp_occ_ff, rsp_occ_in;

   // ------------------------------------------------------------------------
   // Memories: entry store and rank remap table
   // ------------------------------------------------------------------------
   logic                 ent_wr_en, ent_rd_en;
   logic [IDXW-1:0]      ent_wr_addr, ent_rd_addr;
   logic [WORD_BITS-1:0] ent_wr_data, ent_rdata;
   logic                 map_wr_en, map_rd_en;
   logic [IDXW-1:0]      map_wr_addr, map_rd_addr;
   logic [IDXW-1:0]      map_wr_data, map_rdata;

   rcft_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rdata)
   );

   rcft_ram #(
      .WIDTH (IDXW),
      .DEPTH (ENTRIES)
   ) u_remap_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rdata)
   );

   // Fields of the entry word read last cycle
   logic [IDXW-1:0]       rd_ord;
   logic [LIFE_BITS-1:0]  rd_life;
   logic [ROUTE_BITS-1:0] rd_route;
   logic [KEY_BITS-1:0]   rd_key;

   assign rd_ord   = ent_rdata[0 +: IDXW];
   assign rd_life  = ent_rdata[LIFE_LO +: LIFE_BITS];
   assign rd_route = ent_rdata[ROUTE_LO +: ROUTE_BITS];
   assign rd_key   = ent_rdata[KEY_LO +: KEY_BITS];

   // ------------------------------------------------------------------------
   // Sweep control
   // ------------------------------------------------------------------------
   logic                 sweep_end;   // every address issued
   logic                 sweep_done;  // and every read processed
   logic                 issue;
   logic                 p1_live;     // entry in stage one is valid
   logic                 key_match;
   logic                 rsp_free;
   logic [LIFE_BITS-1:0] life_init;

   assign sweep_end  = (cnt_ff == CNTW'(ENTRIES));
   assign sweep_done = sweep_end && !p1_vld_ff && !p2_vld_ff;
   assign issue      = ((state_ff == ST_SCAN) || (state_ff == ST_INSERT) ||
                        (state_ff == ST_RENUM)) && !sweep_end;
   assign p1_live    = p1_vld_ff && valid_ff[p1_idx_ff];
   assign key_match  = p1_live && (rd_key == key_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   // a zero life register still gives one tick of life
   assign life_init  = (ttl_ff == '0) ? LIFE_BITS'(1) : ttl_ff;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_mode == MODE_PUT) || (req_mode == MODE_GET) ||
                   (req_mode == MODE_TICK)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (sweep_done) begin
               if ((mode_ff == MODE_PUT) && !found_ff) begin
                  state_in = ST_INSERT;
               end else if ((mode_ff == MODE_TICK) && (expired_ff != '0)) begin
                  state_in = ST_REMAP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_INSERT: begin
            if (sweep_done) begin
               state_in = ST_RESP;
            end
         end
         ST_REMAP: begin
            if (sweep_end) begin
               state_in = ST_RENUM;
            end
         end
         ST_RENUM: begin
            if (sweep_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and memory control
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_in         = cnt_ff;
      p1_vld_in      = 1'b0;
      p1_idx_in      = cnt_ff[IDXW-1:0];
      p2_vld_in      = 1'b0;
      p2_idx_in      = p1_idx_ff;
      p2_word_in     = ent_rdata;
      mode_in        = mode_ff;
      key_in         = key_ff;
      route_in       = route_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      ttl_in         = csr_valid ? csr_wdata : ttl_ff;
      found_in       = found_ff;
      rt_in          = rt_ff;
      free_found_in  = free_found_ff;
      slot_in        = slot_ff;
      victim_in      = victim_ff;
      status_in      = status_ff;
      expired_in     = expired_ff;
      expmask_in     = expmask_ff;
      run_in         = run_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_route_in   = rsp_route_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_occ_in     = rsp_occ_ff;

      ent_rd_en      = 1'b0;
      ent_rd_addr    = cnt_ff[IDXW-1:0];
      ent_wr_en      = 1'b0;
      ent_wr_addr    = p1_idx_ff;
      ent_wr_data    = ent_rdata;
      map_rd_en      = 1'b0;
      map_rd_addr    = rd_ord;
      map_wr_en      = 1'b0;
      map_wr_addr    = cnt_ff[IDXW-1:0];
      map_wr_data    = IDXW'(cnt_ff - run_ff);

      // advance the sweep: one entry read per cycle
      if (issue) begin
         ent_rd_en = 1'b1;
         p1_vld_in = 1'b1;
         cnt_in    = cnt_ff + CNTW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               key_in        = req_key;
               route_in      = req_route;
               cnt_in        = '0;
               found_in      = 1'b0;
               rt_in         = '0;
               free_found_in = 1'b0;
               status_in     = STATUS_OTHER;
               expired_in    = '0;
               expmask_in    = '0;
               run_in        = '0;
            end
         end

         ST_SCAN: begin
            if (p1_vld_ff) begin
               case (mode_ff)
                  MODE_PUT: begin
                     if (key_match) begin
                        found_in = 1'b1;
                     end
                     if (!valid_ff[p1_idx_ff] && !free_found_ff) begin
                        free_found_in = 1'b1;
                        slot_in       = p1_idx_ff;
                     end
                     // the oldest entry holds the highest rank
                     if (p1_live && (rd_ord == IDXW'(ENTRIES - 1))) begin
                        victim_in = p1_idx_ff;
                     end
                  end
                  MODE_GET: begin
                     if (key_match && !found_ff) begin
                        found_in = 1'b1;
                        rt_in    = rd_route;
                     end
                  end
                  MODE_TICK: begin
                     if (p1_live) begin
                        if (rd_life <= LIFE_BITS'(1)) begin
                           // drop the entry and note the rank it vacates
                           valid_in[p1_idx_ff] = 1'b0;
                           expmask_in[rd_ord]  = 1'b1;
                           expired_in          = expired_ff + CNTW'(1);
                           count_in            = count_ff - CNTW'(1);
                        end else begin
                           ent_wr_en = 1'b1;
                           ent_wr_data[LIFE_LO +: LIFE_BITS] = rd_life - LIFE_BITS'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (sweep_done) begin
               cnt_in = '0;
               if ((mode_ff == MODE_PUT) && found_ff) begin
                  status_in = STATUS_PRESENT;
               end else if (mode_ff == MODE_PUT) begin
                  if (count_ff == CNTW'(ENTRIES)) begin
                     // full: reuse the oldest entry's slot
                     slot_in   = victim_ff;
                     status_in = STATUS_EVICTED;
                  end else begin
                     count_in  = count_ff + CNTW'(1);
                     status_in = STATUS_INSERTED;
                  end
               end
            end
         end

         ST_INSERT: begin
            if (p1_vld_ff) begin
               if (p1_idx_ff == slot_ff) begin
                  ent_wr_en   = 1'b1;
                  ent_wr_data = {key_ff, route_ff, life_init, IDXW'(0)};
                  valid_in[p1_idx_ff] = 1'b1;
               end else if (valid_ff[p1_idx_ff]) begin
                  // age every other entry by one rank
                  ent_wr_en = 1'b1;
                  ent_wr_data[0 +: IDXW] = rd_ord + IDXW'(1);
               end
            end
         end

         ST_REMAP: begin
            // new rank = old rank less the expired ranks below it
            if (!sweep_end) begin
               map_wr_en = 1'b1;
               run_in    = run_ff + CNTW'(expmask_ff[cnt_ff[IDXW-1:0]]);
               cnt_in    = cnt_ff + CNTW'(1);
            end else begin
               cnt_in = '0;
            end
         end

         ST_RENUM: begin
            if (p1_live) begin
               map_rd_en = 1'b1;
               p2_vld_in = 1'b1;
            end
            if (p2_vld_ff) begin
               ent_wr_en   = 1'b1;
               ent_wr_addr = p2_idx_ff;
               ent_wr_data = p2_word_ff;
               ent_wr_data[0 +: IDXW] = map_rdata;
            end
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = (mode_ff == MODE_GET) && found_ff;
               rsp_route_in   = ((mode_ff == MODE_GET) && found_ff) ? rt_ff : '0;
               rsp_status_in  = status_ff;
               rsp_expired_in = expired_ff;
               rsp_occ_in     = count_ff;
            end
         end

         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         ttl_ff       <= TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff      <= p1_idx_in;
      p2_idx_ff      <= p2_idx_in;
      p2_word_ff     <= p2_word_in;
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      route_ff       <= route_in;
      found_ff       <= found_in;
      rt_ff          <= rt_in;
      free_found_ff  <= free_found_in;
      slot_ff        <= slot_in;
      victim_ff      <= victim_in;
      status_ff      <= status_in;
      expired_ff     <= expired_in;
      expmask_ff     <= expmask_in;
      run_ff         <= run_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_route_ff   <= rsp_route_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   // ------------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------------
   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_route_out     = rsp_route_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_count = rsp_expired_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule
`default_nettype wire

### design/rcft_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_checker: port-level checks for the route cache
// Watches the top-level ports and flags inconsistent responses.
// ----------------------------------------------------------------------------
module rcft_checker
   import rcft_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int ROUTE_BITS = 16,
   localparam int CNTW      = $clog2(ENTRIES + 1)
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_hit,
   input wire logic [ROUTE_BITS-1:0]  rsp_route_out,
   input wire logic [STATUS_BITS-1:0] rsp_status,
   input wire logic [CNTW-1:0]        rsp_expired_count,
   input wire logic [CNTW-1:0]        rsp_occupancy
);

   // one item at a time: a transfer in closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while an item is in progress");

   a_hit_is_get: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_status == STATUS_OTHER) && (rsp_expired_count == '0))
      else $error("hit reported on a put or with expiries");

   a_miss_route_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_route_out == '0))
      else $error("route returned without a hit");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNTW'(ENTRIES)))
      else $error("occupancy beyond cache size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_occupancy))
      else $error("stalled response changed");

endmodule

bind route_cache_fifo_ttl_core rcft_checker #(
   .ENTRIES    (ENTRIES),
   .ROUTE_BITS (ROUTE_BITS)
) u_rcft_checker (.*);
`default_nettype wire

### sim/rcft_answer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_answer_check: answer predictor and comparator for the route cache
// Watches the request, response and life-register channels and keeps its own
// copy of the cache entries. Each response is compared with the oldest answer
// still due.
// ----------------------------------------------------------------------------
module rcft_answer_check
   import rcft_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 48,
   parameter int ROUTE_BITS = 16,
   localparam int CNTW      = $clog2(ENTRIES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [ROUTE_BITS-1:0]  req_route,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_hit,
   input  logic [ROUTE_BITS-1:0]  rsp_route_out,
   input  logic [STATUS_BITS-1:0] rsp_status,
   input  logic [CNTW-1:0]        rsp_expired_count,
   input  logic [CNTW-1:0]        rsp_occupancy,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [LIFE_BITS-1:0]   csr_wdata,
   output int                     mismatches,
   output int                     answers_due,
   output int                     answers_checked,
   output int                     hits_seen,
   output int                     evictions_seen,
   output int                     expiries_seen
);

   typedef struct packed {
      logic                   hit;
      logic [ROUTE_BITS-1:0]  route_out;
      logic [STATUS_BITS-1:0] status;
      logic [CNTW-1:0]        expired;
      logic [CNTW-1:0]        occupancy;
   } cache_answer_type;

   // model copy of the entry memory
   logic                  slot_used  [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
   logic [ROUTE_BITS-1:0] slot_route [ENTRIES];
   logic [LIFE_BITS-1:0]  slot_life  [ENTRIES];
   int unsigned           slot_rank  [ENTRIES];
   int unsigned           used_count;
   logic [LIFE_BITS-1:0]  life_setting;

   cache_answer_type due_q [$];

   int errors   = 0;
   int checked  = 0;
   int hits     = 0;
   int evicts   = 0;
   int expires  = 0;
   int due_size = 0;

   assign mismatches      = errors;
   assign answers_due     = due_size;
   assign answers_checked = checked;
   assign hits_seen       = hits;
   assign evictions_seen  = evicts;
   assign expiries_seen   = expires;

   function automatic void clear_cache();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_used[i]  = 1'b0;
         slot_key[i]   = '0;
         slot_route[i] = '0;
         slot_life[i]  = '0;
         slot_rank[i]  = 0;
      end
      used_count   = 0;
      life_setting = TTL_RESET;
   endfunction

   function automatic int find_slot(input logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   // close the gaps in the age ranks, keeping their order
   function automatic void renumber_ranks();
      int unsigned prior [ENTRIES];
      int unsigned rank;
      for (int i = 0; i < ENTRIES; i++)
         prior[i] = slot_rank[i];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i]) begin
            rank = 0;
            for (int j = 0; j < ENTRIES; j++)
               if (slot_used[j] && prior[j] < prior[i])
                  rank++;
            slot_rank[i] = rank;
         end
      end
   endfunction

   function automatic cache_answer_type cache_step(input logic [MODE_BITS-1:0]  mode,
                                                   input logic [KEY_BITS-1:0]   key,
                                                   input logic [ROUTE_BITS-1:0] route);
      cache_answer_type ans;
      int found;
      int victim;
      int free_slot;
      int expired;
      ans.hit       = 1'b0;
      ans.route_out = '0;
      ans.status    = STATUS_OTHER;
      expired       = 0;
      case (mode)
         MODE_PUT: begin
            found = find_slot(key);
            if (found >= 0) begin
               ans.status = STATUS_PRESENT;
            end else begin
               ans.status = STATUS_INSERTED;
               if (used_count >= ENTRIES) begin
                  // drop the oldest entry to make room
                  victim = -1;
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                        victim = i;
                  slot_used[victim] = 1'b0;
                  used_count--;
                  ans.status = STATUS_EVICTED;
               end
               free_slot = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (!slot_used[i] && free_slot < 0)
                     free_slot = i;
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_used[i])
                     slot_rank[i]++;
               slot_used[free_slot]  = 1'b1;
               slot_key[free_slot]   = key;
               slot_route[free_slot] = route;
               slot_life[free_slot]  = (life_setting == '0) ? LIFE_BITS'(1) : life_setting;
               slot_rank[free_slot]  = 0;
               used_count++;
               renumber_ranks();
            end
         end
         MODE_GET: begin
            found = find_slot(key);
            if (found >= 0) begin
               ans.hit       = 1'b1;
               ans.route_out = slot_route[found];
            end
         end
         MODE_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_used[i]) begin
                  if (slot_life[i] <= LIFE_BITS'(1)) begin
                     slot_life[i] = '0;
                     slot_used[i] = 1'b0;
                     used_count--;
                     expired++;
                  end else begin
                     slot_life[i]--;
                  end
               end
            end
            if (expired > 0)
               renumber_ranks();
         end
         default: begin
         end
      endcase
      ans.expired   = CNTW'(expired);
      ans.occupancy = CNTW'(used_count);
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cache_answer_type want;
      if (reset) begin
         clear_cache();
         due_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            life_setting = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (due_q.size() == 0) begin
               $display("%0t: stray response, expected none, got %0h/%0h/%0h/%0d/%0d",
                        $time, rsp_hit, rsp_route_out, rsp_status, rsp_expired_count,
                        rsp_occupancy);
               errors++;
            end else begin
               want = due_q.pop_front();
               check_field("hit", 64'(want.hit), 64'(rsp_hit));
               check_field("route_out", 64'(want.route_out), 64'(rsp_route_out));
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("expired_count", 64'(want.expired), 64'(rsp_expired_count));
               check_field("occupancy", 64'(want.occupancy), 64'(rsp_occupancy));
            end
         end
         if (req_valid && !req_stall) begin
            want = cache_step(req_mode, req_key, req_route);
            due_q.push_back(want);
            if (want.hit)
               hits++;
            if (want.status == STATUS_EVICTED)
               evicts++;
            expires += int'(want.expired);
         end
      end
      due_size = due_q.size();
   end

endmodule

### sim/tb_route_cache_fifo_ttl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_cache_fifo_ttl_core: stimulus and verdict for the route cache
// Drives puts, gets, ticks and life-register writes with random idling on
// both channels; the answer checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_route_cache_fifo_ttl_core
   import rcft_pkg::*;
;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 48;
   localparam int ROUTE_BITS = 16;
   localparam int CNTW       = $clog2(ENTRIES + 1);

   // mode 3 is not decoded by the block: it must answer like a get miss
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam logic [KEY_BITS-1:0]   KEY_ONES   = {KEY_BITS{1'b1}};
   localparam logic [ROUTE_BITS-1:0] ROUTE_ONES = {ROUTE_BITS{1'b1}};

   localparam int ITEM_TARGET    = 450;
   localparam int POOL_KEYS      = 20;   // a few more than ENTRIES, so puts evict
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 3 * ENTRIES + 8;   // slowest item, a tick that expires

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_BITS-1:0]   req_mode;
   logic [KEY_BITS-1:0]    req_key;
   logic [ROUTE_BITS-1:0]  req_route;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_hit;
   logic [ROUTE_BITS-1:0]  rsp_route_out;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [CNTW-1:0]        rsp_expired_count;
   logic [CNTW-1:0]        rsp_occupancy;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [LIFE_BITS-1:0]   csr_wdata;

   int mismatches;
   int pending;
   int answers_checked;
   int hits_seen;
   int evictions_seen;
   int expiries_seen;

   // stimulus bookkeeping
   logic [KEY_BITS-1:0] key_pool [POOL_KEYS];
   int  sent          = 0;
   int  puts_sent     = 0;
   int  gets_sent     = 0;
   int  ticks_sent    = 0;
   int  unused_sent   = 0;
   int  life_writes   = 0;
   int  hold_requests = 0;
   int  holds_done    = 0;
   bit  quiet         = 1'b0;   // no idling on either side while set
   int  idle_cycles   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   route_cache_fifo_ttl_core #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .ROUTE_BITS(ROUTE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_route        (req_route),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_route_out    (rsp_route_out),
      .rsp_status       (rsp_status),
      .rsp_expired_count(rsp_expired_count),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   rcft_answer_check #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .ROUTE_BITS(ROUTE_BITS)
   ) answer_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_route        (req_route),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_route_out    (rsp_route_out),
      .rsp_status       (rsp_status),
      .rsp_expired_count(rsp_expired_count),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .answers_due      (pending),
      .answers_checked  (answers_checked),
      .hits_seen        (hits_seen),
      .evictions_seen   (evictions_seen),
      .expiries_seen    (expiries_seen)
   );

   // Idle gap ahead of a request: mostly none, sometimes a few cycles, rarely long.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly keys from the shared pool so that gets hit and puts collide.
   function automatic logic [KEY_BITS-1:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, POOL_KEYS - 1)];
      return KEY_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ROUTE_BITS-1:0] pick_route();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return '0;
      if (pick < 10)
         return ROUTE_ONES;
      return ROUTE_BITS'($urandom());
   endfunction

   // Life setting per phase: the extremes first, then mid values.
   function automatic logic [LIFE_BITS-1:0] life_for_phase(input int phase);
      case (phase % 8)
         0:       return 8'd1;
         1:       return 8'd255;
         2:       return 8'd0;
         3:       return 8'd2;
         4:       return TTL_RESET;
         5:       return LIFE_BITS'($urandom_range(3, 20));
         6:       return LIFE_BITS'($urandom_range(1, 255));
         default: return 8'd1;
      endcase
   endfunction

   // Offer one request and hold it until the block takes it. Entered and left
   // at a falling edge; valid is left high so back-to-back transfers need no
   // extra edge.
   task automatic send_item(input logic [MODE_BITS-1:0]  mode,
                            input logic [KEY_BITS-1:0]   key,
                            input logic [ROUTE_BITS-1:0] route);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      req_route <= route;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
      case (mode)
         MODE_PUT:  puts_sent++;
         MODE_GET:  gets_sent++;
         MODE_TICK: ticks_sent++;
         default:   unused_sent++;
      endcase
   endtask

   // Drop valid once the last transfer is done; only called straight after
   // send_item, at the same falling edge.
   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   // Wait until every answer has come back; always waits for a falling edge first.
   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
   endtask

   // Life register write, only with the block idle.
   task automatic write_life(input logic [LIFE_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      life_writes++;
   endtask

   task automatic send_random_item();
      int pick;
      logic [MODE_BITS-1:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 42)
         mode = MODE_PUT;
      else if (pick < 75)
         mode = MODE_GET;
      else if (pick < 97)
         mode = MODE_TICK;
      else
         mode = MODE_UNUSED;
      send_item(mode, pick_key(), pick_route());
   endtask

   // Run of puts with fresh keys closed by a tick: with a short life this
   // refills the cache with young entries and then expires many at once.
   task automatic fill_then_tick();
      int count;
      count = $urandom_range(4, ENTRIES + 1);
      repeat (count)
         send_item(MODE_PUT, KEY_BITS'({$urandom(), $urandom()}), pick_route());
      send_item(MODE_TICK, pick_key(), pick_route());
   endtask

   // Receiver: one stall decision per falling edge. A long hold-off counts its
   // own cycles, so the sender keeps offering and the block backs up.
   initial begin
      int stall_left;
      int pick;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            stall_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_stall <= 1'b0;
            end else if (pick < 93) begin
               stall_left = $urandom_range(1, 4) - 1;
               rsp_stall <= 1'b1;
            end else begin
               stall_left = $urandom_range(10, 40) - 1;
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d answers still due",
                  $time, WATCHDOG_LIMIT, pending);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int first;
      int span;
      req_valid = 1'b0;
      req_mode  = MODE_GET;
      req_key   = '0;
      req_route = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      reset     = 1'b1;

      // shared keys, with the all-zero and all-one addresses among them
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < POOL_KEYS; i++)
         key_pool[i] = KEY_BITS'({$urandom(), $urandom()});

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // --- directed part, life at its reset value ---
      send_item(MODE_GET, key_pool[0], pick_route());        // miss on an empty cache
      send_item(MODE_PUT, key_pool[0], ROUTE_ONES);
      send_item(MODE_PUT, key_pool[1], '0);
      send_item(MODE_GET, key_pool[0], '0);                 // hit, all-one route
      send_item(MODE_GET, key_pool[1], ROUTE_ONES);         // hit, zero route
      send_item(MODE_PUT, key_pool[0], 16'h1234);           // already present, no refresh
      send_item(MODE_UNUSED, key_pool[1], ROUTE_ONES);      // unused mode answers as a miss
      send_item(MODE_TICK, '0, '0);                         // ages, nothing expires
      for (int i = 2; i < ENTRIES; i++)
         send_item(MODE_PUT, key_pool[i], pick_route());    // fill every slot
      send_item(MODE_PUT, key_pool[ENTRIES], pick_route()); // full: oldest goes
      send_item(MODE_GET, key_pool[0], '0);                 // the evicted key misses

      // zero life is taken as one tick: the new entry goes on the next tick
      release_req();
      write_life(8'd0);
      send_item(MODE_PUT, key_pool[ENTRIES + 1], pick_route());
      send_item(MODE_TICK, KEY_ONES, ROUTE_ONES);

      // --- random phases, each under its own life setting ---
      phase = 0;
      while (sent < ITEM_TARGET) begin
         release_req();
         write_life(life_for_phase(phase));
         quiet = (phase == 3);
         if (phase == 1)
            hold_requests++;   // long receiver hold-off while requests keep coming
         first = sent;
         span  = $urandom_range(40, 60);
         while (sent - first < span) begin
            if (phase == 2 && sent - first == span / 2) begin
               // pause the sender until every answer is back
               release_req();
               wait_drained();
            end
            if ($urandom_range(0, 99) < 8)
               fill_then_tick();
            else
               send_random_item();
         end
         phase++;
      end

      release_req();
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d items: %0d put, %0d get, %0d tick, %0d bad mode, %0d life writes",
               sent, puts_sent, gets_sent, ticks_sent, unused_sent, life_writes);
      $display("%0d answers compared: %0d hits, %0d evictions, %0d expiries",
               answers_checked, hits_seen, evictions_seen, expiries_seen);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
